/* hdl/hcbd_pkg.sv */
// ---------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helpers shared by the chunked body decoder modules.
// ---------------------------------------------------------------------------
package hcbd_pkg;

   typedef enum logic [2:0] {
      PH_SIZE    = 3'd0,
      PH_DATA    = 3'd1,
      PH_DCRLF   = 3'd2,
      PH_TRAILER = 3'd3,
      PH_DONE    = 3'd4
   } phase_type;

   // status codes
   localparam logic [1:0] ST_MORE  = 2'd0;
   localparam logic [1:0] ST_DONE  = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_SIZE_LONG    = 3'd1;
   localparam logic [2:0] ERR_EMPTY_SIZE   = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX      = 3'd3;
   localparam logic [2:0] ERR_CHUNK_LARGE  = 3'd4;
   localparam logic [2:0] ERR_BODY_LARGE   = 3'd5;
   localparam logic [2:0] ERR_NO_CRLF      = 3'd6;
   localparam logic [2:0] ERR_TRAILER_LONG = 3'd7;

   // register indexes
   localparam logic [1:0] CSR_BODY_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_SIZE_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_TRAILER_LIMIT = 2'd2;

   localparam logic [31:0] BODY_LIMIT_RST    = 32'd1048576;
   localparam logic [15:0] SIZE_LIMIT_RST    = 16'd4096;
   localparam logic [15:0] TRAILER_LIMIT_RST = 16'd8192;

   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic [2:0] error_code;
      logic [1:0] status;
      logic [7:0] data_byte;
      logic       data_valid;
   } result_type;

   // {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, ch[3:0]};
      end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
         r = {1'b1, ch[3:0] + 4'd9};
      end
      return r;
   endfunction

   function automatic logic [RSP_DATA_W-1:0] pack_result(input result_type r);
      return {2'b00, r};
   endfunction

endpackage

/* hdl/hcbd_core.sv */
// ---------------------------------------------------------------------------
// hcbd_core
// Per-byte parser: size line, data, data CRLF, trailer lines; config regs.
// ---------------------------------------------------------------------------
module hcbd_core import hcbd_pkg::*; #(
   parameter int BODY_LIMIT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        push,
   input  logic [7:0]  in_byte,
   output result_type  result
);

   localparam int LIM_W  = (BODY_LIMIT_BITS < 32) ? BODY_LIMIT_BITS : 32;
   localparam int SIZE_W = LIM_W + 4;

   logic [31:0]       body_lim_ff;
   logic [15:0]       size_lim_ff, trl_lim_ff;

   phase_type         phase_ff, phase_in;
   logic [15:0]       line_len_ff, line_len_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              digit_nz_ff, digit_nz_in;
   logic              in_ext_ff, in_ext_in;
   logic              pend_cr_ff, pend_cr_in;
   logic [2:0]        line_err_ff, line_err_in;
   logic [LIM_W-1:0]  chunk_left_ff, chunk_left_in;
   logic [LIM_W:0]    body_cnt_ff, body_cnt_in;
   logic              crlf_pos_ff, crlf_pos_in;
   logic [2:0]        sticky_ff, sticky_in;

   logic [LIM_W-1:0]  body_limit;
   logic [15:0]       line_limit;
   logic              is_size;
   logic [4:0]        hex;
   logic [SIZE_W-1:0] size_b;
   logic [LIM_W:0]    cnt_next;

   assign body_limit = body_lim_ff[LIM_W-1:0];
   assign hex        = hex_digit(in_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         body_lim_ff <= BODY_LIMIT_RST;
         size_lim_ff <= SIZE_LIMIT_RST;
         trl_lim_ff  <= TRAILER_LIMIT_RST;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_BODY_LIMIT:    body_lim_ff <= csr_wdata;
            CSR_SIZE_LIMIT:    size_lim_ff <= csr_wdata[15:0];
            CSR_TRAILER_LIMIT: trl_lim_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SIZE;
         line_len_ff   <= '0;
         size_ff       <= '0;
         digit_nz_ff   <= 1'b0;
         in_ext_ff     <= 1'b0;
         pend_cr_ff    <= 1'b0;
         line_err_ff   <= ERR_NONE;
         chunk_left_ff <= '0;
         body_cnt_ff   <= '0;
         crlf_pos_ff   <= 1'b0;
         sticky_ff     <= ERR_NONE;
      end else if (push) begin
         phase_ff      <= phase_in;
         line_len_ff   <= line_len_in;
         size_ff       <= size_in;
         digit_nz_ff   <= digit_nz_in;
         in_ext_ff     <= in_ext_in;
         pend_cr_ff    <= pend_cr_in;
         line_err_ff   <= line_err_in;
         chunk_left_ff <= chunk_left_in;
         body_cnt_ff   <= body_cnt_in;
         crlf_pos_ff   <= crlf_pos_in;
         sticky_ff     <= sticky_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      line_len_in   = line_len_ff;
      size_in       = size_ff;
      digit_nz_in   = digit_nz_ff;
      in_ext_in     = in_ext_ff;
      pend_cr_in    = pend_cr_ff;
      line_err_in   = line_err_ff;
      chunk_left_in = chunk_left_ff;
      body_cnt_in   = body_cnt_ff;
      crlf_pos_in   = crlf_pos_ff;
      sticky_in     = sticky_ff;
      is_size       = (phase_ff == PH_SIZE);
      line_limit    = is_size ? size_lim_ff : trl_lim_ff;
      size_b        = {size_ff[SIZE_W-5:0], hex[3:0]};
      cnt_next      = (&body_cnt_ff) ? body_cnt_ff : body_cnt_ff + 1'b1;
      result.data_valid = 1'b0;
      result.data_byte  = 8'd0;

      if (sticky_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_SIZE, PH_TRAILER: begin
               if (pend_cr_ff && in_byte == CH_LF) begin
                  // line complete
                  line_len_in = '0;
                  size_in     = '0;
                  digit_nz_in = 1'b0;
                  in_ext_in   = 1'b0;
                  pend_cr_in  = 1'b0;
                  line_err_in = ERR_NONE;
                  if (is_size) begin
                     if (!digit_nz_ff) begin
                        sticky_in = ERR_EMPTY_SIZE;
                     end else if (line_err_ff != ERR_NONE) begin
                        sticky_in = line_err_ff;
                     end else if (size_ff == '0) begin
                        phase_in = PH_TRAILER;
                     end else begin
                        chunk_left_in = size_ff[LIM_W-1:0];
                        phase_in      = PH_DATA;
                     end
                  end else if (line_len_ff <= 16'd1) begin
                     phase_in = PH_DONE;
                  end
               end else begin
                  // a held CR not followed by LF is a content byte
                  if (pend_cr_ff && is_size && !in_ext_ff) begin
                     digit_nz_in = 1'b1;
                     if (line_err_ff == ERR_NONE) line_err_in = ERR_BAD_HEX;
                  end
                  pend_cr_in = 1'b0;
                  if (line_len_ff >= line_limit) begin
                     sticky_in = is_size ? ERR_SIZE_LONG : ERR_TRAILER_LONG;
                  end else begin
                     line_len_in = line_len_ff + 16'd1;
                     if (in_byte == CH_CR) begin
                        pend_cr_in = 1'b1;
                     end else if (is_size && !in_ext_in) begin
                        if (in_byte == CH_SEMI) begin
                           in_ext_in = 1'b1;
                        end else begin
                           digit_nz_in = 1'b1;
                           if (line_err_in == ERR_NONE) begin
                              if (!hex[4]) begin
                                 line_err_in = ERR_BAD_HEX;
                              end else begin
                                 size_in = size_b;
                                 if (size_b > {4'd0, body_limit}) line_err_in = ERR_CHUNK_LARGE;
                              end
                           end
                        end
                     end
                  end
               end
            end
            PH_DATA: begin
               body_cnt_in = cnt_next;
               if (cnt_next > {1'b0, body_limit}) begin
                  sticky_in = ERR_BODY_LARGE;
               end else begin
                  result.data_valid = 1'b1;
                  result.data_byte  = in_byte;
                  if (chunk_left_ff != '0) chunk_left_in = chunk_left_ff - 1'b1;
                  if (chunk_left_ff <= {{(LIM_W-1){1'b0}}, 1'b1}) begin
                     phase_in    = PH_DCRLF;
                     crlf_pos_in = 1'b0;
                     line_err_in = ERR_NONE;
                  end
               end
            end
            PH_DCRLF: begin
               if (!crlf_pos_ff) begin
                  line_err_in = (in_byte != CH_CR) ? ERR_NO_CRLF : ERR_NONE;
                  crlf_pos_in = 1'b1;
               end else begin
                  crlf_pos_in = 1'b0;
                  if (line_err_ff != ERR_NONE || in_byte != CH_LF) begin
                     sticky_in = ERR_NO_CRLF;
                  end else begin
                     line_len_in = '0;
                     size_in     = '0;
                     digit_nz_in = 1'b0;
                     in_ext_in   = 1'b0;
                     pend_cr_in  = 1'b0;
                     line_err_in = ERR_NONE;
                     phase_in    = PH_SIZE;
                  end
               end
            end
            PH_DONE: ;
            default: phase_in = PH_DONE;
         endcase
      end

      result.error_code = sticky_in;
      if (sticky_in != ERR_NONE) begin
         result.status     = ST_ERROR;
         result.data_valid = 1'b0;
         result.data_byte  = 8'd0;
      end else if (phase_in == PH_DONE) begin
         result.status = ST_DONE;
      end else begin
         result.status = ST_MORE;
      end
   end

endmodule

/* hdl/hcbd_out_buf.sv */
// ---------------------------------------------------------------------------
// hcbd_out_buf
// Result register with a skid entry; input side is ready while skid is free.
// ---------------------------------------------------------------------------
module hcbd_out_buf import hcbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  result_type            push_data,
   output logic                  push_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;

   assign push_ready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = pack_result(out_data_ff);

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* hdl/http_chunked_body_decoder.sv */
// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// Decodes a chunked HTTP/1.1 body one byte at a time into payload bytes.
// ---------------------------------------------------------------------------
//  channel | direction | tdata fields (low bit up)
//  req_    | in        | in_byte[7:0]
//  rsp_    | out       | data_valid, data_byte[7:0], status[1:0], error_code[2:0], pad
//  csr_    | in        | index 0 body limit, 1 size_line_limit, 2 trailer_line_limit
//
//  One byte accepted per cycle while req_tready is high; each byte yields one
//  registered result. A result register plus one skid entry decouple the
//  two channels, so req_tready drops only when both hold.
//  Synchronous active-high reset clears state and loads register defaults.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; #(
   parameter int BODY_LIMIT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // in_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // data_valid, data_byte, status, error_code
   input  logic                  csr_wen,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   logic       push;
   result_type result;

   assign push = req_tvalid && req_tready;

   hcbd_core #(
      .BODY_LIMIT_BITS(BODY_LIMIT_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .push      (push),
      .in_byte   (req_tdata),
      .result    (result)
   );

   hcbd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (result),
      .push_ready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hdl/hcbd_checker.sv */
// ---------------------------------------------------------------------------
// hcbd_checker
// Port-level checks on result stream consistency, bound to the top level.
// ---------------------------------------------------------------------------
module hcbd_checker import hcbd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       rsp_xfer;
   logic       data_valid;
   logic [1:0] status;
   logic [2:0] error_code;
   logic       err_seen_ff, done_seen_ff;

   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign data_valid = rsp_tdata[0];
   assign status     = rsp_tdata[10:9];
   assign error_code = rsp_tdata[13:11];

   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff  <= 1'b0;
         done_seen_ff <= 1'b0;
      end else if (rsp_xfer) begin
         if (status == ST_ERROR) err_seen_ff <= 1'b1;
         if (status == ST_DONE) done_seen_ff <= 1'b1;
      end
   end

   // errors are sticky
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && err_seen_ff |-> status == ST_ERROR)
      else $error("result after an error not flagged as error");

   // completion is final
   a_done_final: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && done_seen_ff |-> status == ST_DONE)
      else $error("result after completion not flagged complete");

   a_code_match: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (error_code != ERR_NONE) == (status == ST_ERROR))
      else $error("error code and status disagree");

   a_data_more: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && data_valid |-> status == ST_MORE)
      else $error("payload byte with terminal status");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result transfer changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
